[hdl/fss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and coordinate helpers for the free space subtract
// block.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int COORD_BITS = 16;
  localparam int CORNER_W   = 48;
  localparam int LEN_W      = 17;
  localparam int WID_W      = 16;
  localparam int NUM_SIDES  = 7;

  // packed view wide enough for three coordinates or one corner
  localparam int PACK_W = (3 * COORD_BITS > CORNER_W) ? 3 * COORD_BITS : CORNER_W;
  localparam int SUM_W  = ((COORD_BITS > WID_W) ? COORD_BITS : WID_W) + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CORNER_W-1:0]   corner_t;

  localparam coord_t COORD_MAX = '1;

  typedef enum logic [2:0] {
    SIDE_X_ABOVE    = 3'd0,
    SIDE_Y_ABOVE    = 3'd1,
    SIDE_Z_FULL     = 3'd2,
    SIDE_Z_FOOTPRNT = 3'd3,
    SIDE_X_BELOW    = 3'd4,
    SIDE_Y_BELOW    = 3'd5,
    SIDE_Z_BELOW    = 3'd6
  } side_t;

  typedef struct packed {
    corner_t rmin;
    corner_t rmax;
    side_t   side;
  } residual_t;

  // all residual candidates of one item, one slot per side code
  typedef struct packed {
    logic [NUM_SIDES-1:0]           mask;
    residual_t [NUM_SIDES-1:0]      res;
  } job_t;

  function automatic coord_t get_coord(corner_t c, logic [1:0] idx);
    logic [PACK_W-1:0] e;
    e = PACK_W'(c);
    return e[idx*COORD_BITS +: COORD_BITS];
  endfunction

  function automatic corner_t pack3(coord_t x, coord_t y, coord_t z);
    logic [PACK_W-1:0] e;
    e = '0;
    e[0 +: COORD_BITS]            = x;
    e[COORD_BITS +: COORD_BITS]   = y;
    e[2*COORD_BITS +: COORD_BITS] = z;
    return e[CORNER_W-1:0];
  endfunction

  function automatic coord_t sat_add(coord_t a, logic [WID_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return s[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/fss_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fss_calc
// Computes every residual candidate of one item and which sides exist.
// ----------------------------------------------------------------------------
module fss_calc (
  input  fss_pkg::corner_t               space_min,
  input  fss_pkg::corner_t               space_max,
  input  fss_pkg::corner_t               block_min,
  input  fss_pkg::corner_t               block_max,
  input  logic signed [fss_pkg::LEN_W-1:0] support_len,
  input  logic [fss_pkg::WID_W-1:0]      support_wid,
  output fss_pkg::job_t                  job
);
  import fss_pkg::*;

  coord_t sx0, sy0, sz0, sx1, sy1, sz1;
  coord_t bx0, by0, bz0, bx1, by1, bz1;
  logic   full;

  assign sx0 = get_coord(space_min, 2'd0);
  assign sy0 = get_coord(space_min, 2'd1);
  assign sz0 = get_coord(space_min, 2'd2);
  assign sx1 = get_coord(space_max, 2'd0);
  assign sy1 = get_coord(space_max, 2'd1);
  assign sz1 = get_coord(space_max, 2'd2);
  assign bx0 = get_coord(block_min, 2'd0);
  assign by0 = get_coord(block_min, 2'd1);
  assign bz0 = get_coord(block_min, 2'd2);
  assign bx1 = get_coord(block_max, 2'd0);
  assign by1 = get_coord(block_max, 2'd1);
  assign bz1 = get_coord(block_max, 2'd2);

  // any negative length selects the full space above
  assign full = support_len[LEN_W-1];

  always_comb begin
    job.mask[SIDE_X_ABOVE]    = bx1 < sx1;
    job.mask[SIDE_Y_ABOVE]    = by1 < sy1;
    job.mask[SIDE_Z_FULL]     = (bz1 < sz1) && full;
    job.mask[SIDE_Z_FOOTPRNT] = (bz1 < sz1) && !full;
    job.mask[SIDE_X_BELOW]    = bx0 > sx0;
    job.mask[SIDE_Y_BELOW]    = by0 > sy0;
    job.mask[SIDE_Z_BELOW]    = bz0 > sz0;

    job.res[SIDE_X_ABOVE] = '{rmin: pack3(bx1, sy0, sz0), rmax: space_max,
                              side: SIDE_X_ABOVE};
    job.res[SIDE_Y_ABOVE] = '{rmin: pack3(sx0, by1, sz0), rmax: space_max,
                              side: SIDE_Y_ABOVE};
    job.res[SIDE_Z_FULL]  = '{rmin: pack3(sx0, sy0, bz1), rmax: space_max,
                              side: SIDE_Z_FULL};
    job.res[SIDE_Z_FOOTPRNT] = '{
      rmin: pack3(bx0, by0, bz1),
      rmax: pack3(sat_add(bx0, support_len[LEN_W-2:0]), sat_add(by0, support_wid), sz1),
      side: SIDE_Z_FOOTPRNT};
    job.res[SIDE_X_BELOW] = '{rmin: space_min, rmax: pack3(bx0, sy1, sz1),
                              side: SIDE_X_BELOW};
    job.res[SIDE_Y_BELOW] = '{rmin: space_min, rmax: pack3(sx1, by0, sz1),
                              side: SIDE_Y_BELOW};
    job.res[SIDE_Z_BELOW] = '{rmin: space_min, rmax: pack3(sx1, sy1, bz0),
                              side: SIDE_Z_BELOW};
  end

endmodule

`default_nettype wire

[hdl/fss_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fss_emit
// Holds the residuals of one item and sends them out one per cycle, in side
// order, through a result register, as long as out_ready is not held low.
// ----------------------------------------------------------------------------
module fss_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fss_pkg::job_t         job_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fss_pkg::residual_t    out_res,
  output logic                  out_last
);
  import fss_pkg::*;

  job_t                 job_r, job_nxt;
  logic [NUM_SIDES-1:0] pend_r, pend_nxt, pick, pend_left;
  logic                 out_valid_r, out_valid_nxt;
  residual_t            out_res_r, out_res_nxt, sel;
  logic                 out_last_r, out_last_nxt;
  logic                 load;

  // lowest pending side goes next
  assign pick      = pend_r & (~pend_r + NUM_SIDES'(1));
  assign load      = (pend_r != '0) && (!out_valid_r || out_ready);
  assign pend_left = load ? (pend_r & ~pick) : pend_r;
  assign in_ready  = pend_left == '0;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SIDES; i++) begin
      if (pick[i]) begin
        sel = sel | job_r.res[i];
      end
    end
  end

  always_comb begin
    pend_nxt      = pend_left;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    if (in_valid && in_ready) begin
      pend_nxt = job_in.mask;
      job_nxt  = job_in;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = sel;
      out_last_nxt  = (pend_r & ~pick) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  // the two z-above forms exclude each other
  a_z_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r[SIDE_Z_FULL] && pend_r[SIDE_Z_FOOTPRNT]))
    else $error("both z-above residuals pending");

  // a non-final residual leaves work behind
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    load && ((pend_r & ~pick) != '0) |=> pend_r != '0)
    else $error("pending residuals lost");

  // pending work with a free result register is always moved out
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("result register not loaded");

  // at most six sides can exist for one item
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pend_r) <= 6)
    else $error("too many residuals pending");

endmodule

`default_nettype wire

[hdl/free_space_subtract_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// free_space_subtract_top
// Residual maximal spaces of a free space minus a placed block.
// ----------------------------------------------------------------------------
// first residual: job register, then result register
// throughput: one residual per cycle while out_ready is high, limited by the
//   single result register
// the next item is taken in the same cycle its last residual enters the
//   result register
// reset: synchronous, active low; clears pending work and output valid
module free_space_subtract_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fss_pkg::CORNER_W-1:0]     in_space_min,
  input  logic [fss_pkg::CORNER_W-1:0]     in_space_max,
  input  logic [fss_pkg::CORNER_W-1:0]     in_block_min,
  input  logic [fss_pkg::CORNER_W-1:0]     in_block_max,
  input  logic signed [fss_pkg::LEN_W-1:0] in_support_len,
  input  logic [fss_pkg::WID_W-1:0]        in_support_wid,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fss_pkg::CORNER_W-1:0]     out_residual_min,
  output logic [fss_pkg::CORNER_W-1:0]     out_residual_max,
  output logic [2:0]                       out_side_code,
  output logic                             out_last_flag
);
  import fss_pkg::*;

  job_t      job;
  residual_t res;

  // compares and footprint sums for all seven sides, straight off the ports
  fss_calc u_calc (
    .space_min   (in_space_min),
    .space_max   (in_space_max),
    .block_min   (in_block_min),
    .block_max   (in_block_max),
    .support_len (in_support_len),
    .support_wid (in_support_wid),
    .job         (job)
  );

  // job register plus result register; drains the sides in fixed order
  fss_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .job_in    (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_last  (out_last_flag)
  );

  assign out_residual_min = res.rmin;
  assign out_residual_max = res.rmax;
  assign out_side_code    = res.side;

endmodule

`default_nettype wire
